// ===== hw/rtl/sorted_priority_queue_dedup_core_defines.svh =====
// assertion macros for the sorted priority queue core
`ifndef SORTED_PRIORITY_QUEUE_DEDUP_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEDUP_CORE_DEFINES_SVH

// same-cycle implication under reset
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
`timescale 1ns / 1ps
package spq_pkg;
  localparam int CAPACITY  = 64;
  localparam int KEY_BITS  = 16;
  localparam int PRIO_BITS = 32;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  typedef struct packed {
    logic                 used;
    logic [KEY_BITS-1:0]  key;
    logic [PRIO_BITS-1:0] prio;
  } spq_slot_t;

  typedef struct packed {
    logic pop;
    logic ins_act;
    logic merge;
  } spq_ctrl_t;

  typedef struct packed {
    logic      pop;
    logic      ins_act;
    spq_slot_t head;
    spq_slot_t head_nxt;
  } spq_stat_t;
endpackage

// ===== hw/rtl/spq_if.sv =====
// handshake channel interfaces for request and result words
`timescale 1ns / 1ps
interface spq_in_if;
  import spq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [KEY_BITS-1:0]  entry_key;
  logic [PRIO_BITS-1:0] entry_priority;
  modport source (output valid, output kind, output entry_key, output entry_priority,
                  input ready);
  modport sink (input valid, input kind, input entry_key, input entry_priority,
                output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 popped_valid;
  logic [KEY_BITS-1:0]  popped_key;
  logic [PRIO_BITS-1:0] popped_priority;
  logic [KEY_BITS-1:0]  head_key;
  logic [PRIO_BITS-1:0] head_priority;
  logic                 is_empty;
  logic [CNT_BITS-1:0]  entry_count;
  logic                 overflow;
  modport source (output valid, output popped_valid, output popped_key,
                  output popped_priority, output head_key, output head_priority,
                  output is_empty, output entry_count, output overflow, input ready);
  modport sink (input valid, input popped_valid, input popped_key,
                input popped_priority, input head_key, input head_priority,
                input is_empty, input entry_count, input overflow, output ready);
endinterface

// ===== hw/rtl/sorted_priority_queue_dedup_core.sv =====
// the result word of an accepted request word is registered and valid in the next cycle
// throughput: one word per cycle while result words are taken, the cell row compares and shifts in a single step
// a waiting result word holds the input off until it is taken
// reset: synchronous active low, empties the queue and drops any pending result word
// no clearing pass: slot contents stay unwritten until filled
`timescale 1ns / 1ps
`include "sorted_priority_queue_dedup_core_defines.svh"
module sorted_priority_queue_dedup_core import spq_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

  logic                 accept;
  logic                 full;
  spq_stat_t            stat;
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic                 out_valid_r;
  logic                 popped_valid_r;
  logic [KEY_BITS-1:0]  popped_key_r;
  logic [PRIO_BITS-1:0] popped_priority_r;
  logic [KEY_BITS-1:0]  head_key_r;
  logic [PRIO_BITS-1:0] head_priority_r;
  logic                 is_empty_r;
  logic [CNT_BITS-1:0]  entry_count_r;
  logic                 overflow_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CAP_CNT);

  spq_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .kind   (in_ch.kind),
    .key    (in_ch.entry_key),
    .prio   (in_ch.entry_priority),
    .stat   (stat)
  );

  always_comb begin
    count_nxt = count_r;
    if (stat.pop) begin
      count_nxt = count_r - 1'b1;
    end else if (stat.ins_act && !full) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_valid_r    <= stat.pop;
      popped_key_r      <= stat.pop ? stat.head.key : '0;
      popped_priority_r <= stat.pop ? stat.head.prio : '0;
      head_key_r        <= stat.head_nxt.used ? stat.head_nxt.key : '0;
      head_priority_r   <= stat.head_nxt.used ? stat.head_nxt.prio : '0;
      is_empty_r        <= (count_nxt == '0);
      entry_count_r     <= count_nxt;
      overflow_r        <= stat.ins_act && full;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.popped_valid    = popped_valid_r;
  assign out_ch.popped_key      = popped_key_r;
  assign out_ch.popped_priority = popped_priority_r;
  assign out_ch.head_key        = head_key_r;
  assign out_ch.head_priority   = head_priority_r;
  assign out_ch.is_empty        = is_empty_r;
  assign out_ch.entry_count     = entry_count_r;
  assign out_ch.overflow        = overflow_r;

  `SPQ_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CAP_CNT, "entry count beyond capacity")
  `SPQ_ASSERT_IMPL(a_head_matches_count, 1'b1, stat.head.used == (count_r != '0),
                   "head slot and count disagree")
  `SPQ_ASSERT_NEXT(a_pop_no_overflow, accept && (in_ch.kind == KIND_POP),
                   out_valid_r && !overflow_r, "pop reported overflow")
  `SPQ_ASSERT_NEXT(a_empty_matches_count, accept, is_empty_r == (entry_count_r == '0),
                   "empty flag and count disagree")
endmodule

// ===== hw/rtl/spq_cell.sv =====
// one queue slot with local compare and neighbour shift
`timescale 1ns / 1ps
module spq_cell import spq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spq_ctrl_t            ctrl,
  input  logic [KEY_BITS-1:0]  key,
  input  logic [PRIO_BITS-1:0] prio,
  input  spq_slot_t            left_slot,
  input  logic                 left_lower,
  input  spq_slot_t            right_slot,
  output spq_slot_t            slot,
  output spq_slot_t            slot_nxt,
  output logic                 lower,
  output logic                 keep_hit,
  output logic                 merge_hit
);
  spq_slot_t slot_r;
  spq_slot_t new_slot;
  logic      eq;

  assign lower     = slot_r.used && (slot_r.prio < prio);
  assign eq        = slot_r.used && (slot_r.key == key);
  assign keep_hit  = eq && !lower;
  assign merge_hit = eq && lower && !left_lower;
  assign new_slot  = '{used: 1'b1, key: key, prio: prio};
  assign slot      = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.pop) begin
      slot_nxt = right_slot;
    end else if (ctrl.ins_act) begin
      if (left_lower) begin
        slot_nxt = left_slot;
      end else if (lower || (left_slot.used && !slot_r.used)) begin
        slot_nxt = new_slot;
      end
    end else if (ctrl.merge && merge_hit) begin
      slot_nxt.prio = prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.used <= 1'b0;
    end else begin
      slot_r.used <= slot_nxt.used;
    end
    slot_r.key  <= slot_nxt.key;
    slot_r.prio <= slot_nxt.prio;
  end
endmodule

// ===== hw/rtl/spq_chain.sv =====
// row of queue cells with the outcome reductions
`timescale 1ns / 1ps
module spq_chain import spq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 kind,
  input  logic [KEY_BITS-1:0]  key,
  input  logic [PRIO_BITS-1:0] prio,
  output spq_stat_t            stat
);
  spq_ctrl_t            ctrl;
  spq_slot_t            slots     [CAPACITY];
  spq_slot_t            slots_nxt [CAPACITY];
  logic [CAPACITY-1:0]  lower_vec;
  logic [CAPACITY-1:0]  keep_vec;
  logic [CAPACITY-1:0]  merge_vec;
  logic                 keep_any;
  logic                 merge_any;

  localparam spq_slot_t HEAD_GUARD = '{used: 1'b1, key: '0, prio: '0};
  localparam spq_slot_t TAIL_GUARD = '{used: 1'b0, key: '0, prio: '0};

  assign keep_any  = |keep_vec;
  assign merge_any = |merge_vec;

  always_comb begin
    ctrl.pop     = accept && (kind == KIND_POP) && slots[0].used;
    ctrl.ins_act = accept && (kind == KIND_INSERT) && !keep_any && !merge_any;
    ctrl.merge   = accept && (kind == KIND_INSERT) && !keep_any && merge_any;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_slot_t left_s;
    spq_slot_t right_s;
    logic      left_l;
    if (i == 0) begin : g_head
      assign left_s = HEAD_GUARD;
      assign left_l = 1'b0;
    end else begin : g_mid
      assign left_s = slots[i-1];
      assign left_l = lower_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_s = TAIL_GUARD;
    end else begin : g_body
      assign right_s = slots[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .key        (key),
      .prio       (prio),
      .left_slot  (left_s),
      .left_lower (left_l),
      .right_slot (right_s),
      .slot       (slots[i]),
      .slot_nxt   (slots_nxt[i]),
      .lower      (lower_vec[i]),
      .keep_hit   (keep_vec[i]),
      .merge_hit  (merge_vec[i])
    );
  end

  always_comb begin
    stat.pop      = ctrl.pop;
    stat.ins_act  = ctrl.ins_act;
    stat.head     = slots[0];
    stat.head_nxt = slots_nxt[0];
  end
endmodule
